/* sv/kfmm_pkg.sv */
// Package for the key frequency min/max tracker.
// Holds parameter defaults, request codes, the sequencer state type and the
// control group passed from the sequencer to the ring head.
package kfmm_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic OP_INC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } kfmm_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } kfmm_ctrl_t;

endpackage

/* sv/kfmm_cell.sv */
// One slot of the rotating table: key, count and occupied flag.
// Takes the entry of its neighbour on every shift; depends on kfmm_pkg for
// its parameter defaults and through the house import.
module kfmm_cell #(
  parameter int KEY_BITS   = kfmm_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = kfmm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift,
  input  logic [KEY_BITS-1:0]   d_key,
  input  logic [COUNT_BITS-1:0] d_count,
  input  logic                  d_used,
  output logic [KEY_BITS-1:0]   q_key,
  output logic [COUNT_BITS-1:0] q_count,
  output logic                  q_used
);
  import kfmm_pkg::*;

  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      used_r  <= 1'b0;
    end else if (shift) begin
      count_r <= d_count;
      used_r  <= d_used;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r <= d_key;
    end
  end

  assign q_key   = key_r;
  assign q_count = count_r;
  assign q_used  = used_r;

endmodule

/* sv/kfmm_head.sv */
// Ring head: looks at the entry leaving slot 0, rewrites it and folds it
// into the request result. Scan pass finds a hit and a free slot; apply
// pass updates the table and tracks max/min. Depends on kfmm_pkg.
module kfmm_head #(
  parameter int KEY_BITS   = kfmm_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = kfmm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kfmm_pkg::kfmm_ctrl_t  ctrl,
  input  logic                  req_type,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [KEY_BITS-1:0]   e_key,
  input  logic [COUNT_BITS-1:0] e_count,
  input  logic                  e_used,
  output logic [KEY_BITS-1:0]   w_key,
  output logic [COUNT_BITS-1:0] w_count,
  output logic                  w_used,
  output logic [COUNT_BITS-1:0] key_count,
  output logic [KEY_BITS-1:0]   max_key,
  output logic [COUNT_BITS-1:0] max_count,
  output logic [KEY_BITS-1:0]   min_key,
  output logic [COUNT_BITS-1:0] min_count,
  output logic                  is_empty,
  output logic                  dropped,
  output logic                  was_absent
);
  import kfmm_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic                  hit_r, hit_nxt;
  logic                  free_r, free_nxt;
  logic                  ins_r, ins_nxt;
  logic                  any_r, any_nxt;
  logic [COUNT_BITS-1:0] kc_r, kc_nxt;
  logic [KEY_BITS-1:0]   maxk_r, maxk_nxt;
  logic [COUNT_BITS-1:0] maxc_r, maxc_nxt;
  logic [KEY_BITS-1:0]   mink_r, mink_nxt;
  logic [COUNT_BITS-1:0] minc_r, minc_nxt;
  logic                  match;

  assign match = e_used && (e_key == key_r);

  always_comb begin
    w_key    = e_key;
    w_count  = e_count;
    w_used   = e_used;
    hit_nxt  = hit_r;
    free_nxt = free_r;
    ins_nxt  = ins_r;
    any_nxt  = any_r;
    kc_nxt   = kc_r;
    maxk_nxt = maxk_r;
    maxc_nxt = maxc_r;
    mink_nxt = mink_r;
    minc_nxt = minc_r;
    if (ctrl.scan) begin
      if (match) begin
        hit_nxt = 1'b1;
      end
      if (!e_used) begin
        free_nxt = 1'b1;
      end
    end
    if (ctrl.apply) begin
      case (op_r)
        OP_INC: begin
          if (match) begin
            if (e_count != COUNT_MAX) begin
              w_count = e_count + COUNT_ONE;
            end
            kc_nxt = w_count;
          end else if (!hit_r && !ins_r && !e_used) begin
            w_key   = key_r;
            w_count = COUNT_ONE;
            w_used  = 1'b1;
            ins_nxt = 1'b1;
            kc_nxt  = COUNT_ONE;
          end
        end
        OP_DEC: begin
          if (match) begin
            if (e_count <= COUNT_ONE) begin
              w_count = '0;
              w_used  = 1'b0;
            end else begin
              w_count = e_count - COUNT_ONE;
            end
            kc_nxt = w_count;
          end
        end
        default: begin
        end
      endcase
      if (w_used) begin
        if (!any_r) begin
          any_nxt  = 1'b1;
          maxk_nxt = w_key;
          maxc_nxt = w_count;
          mink_nxt = w_key;
          minc_nxt = w_count;
        end else begin
          if (w_count > maxc_r) begin
            maxk_nxt = w_key;
            maxc_nxt = w_count;
          end
          if (w_count < minc_r) begin
            mink_nxt = w_key;
            minc_nxt = w_count;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      ins_r  <= 1'b0;
      any_r  <= 1'b0;
    end else if (ctrl.load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      ins_r  <= 1'b0;
      any_r  <= 1'b0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
      ins_r  <= ins_nxt;
      any_r  <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r   <= req_type;
      key_r  <= req_key;
      kc_r   <= '0;
      maxk_r <= '0;
      maxc_r <= '0;
      mink_r <= '0;
      minc_r <= '0;
    end else begin
      kc_r   <= kc_nxt;
      maxk_r <= maxk_nxt;
      maxc_r <= maxc_nxt;
      mink_r <= mink_nxt;
      minc_r <= minc_nxt;
    end
  end

  assign key_count  = kc_r;
  assign max_key    = maxk_r;
  assign max_count  = maxc_r;
  assign min_key    = mink_r;
  assign min_count  = minc_r;
  assign is_empty   = !any_r;
  assign dropped    = (op_r == OP_INC) && !hit_r && !free_r;
  assign was_absent = (op_r == OP_DEC) && !hit_r;

endmodule

/* sv/key_frequency_min_max_tracker_unit.sv */
// Top level of the key frequency min/max tracker.
// Instantiates the ring of kfmm_cell slots, the kfmm_head and the sequencer;
// depends on kfmm_pkg.
//
// Usage:
//   Command channel: drive in_req_type and in_key with start high; the beat
//   is taken at an edge where busy is low. in_req_type OP_INC counts the key
//   up (inserting it into the lowest free slot), OP_DEC counts it down
//   (removing it at one).
//   Result channel: out_valid is high for exactly one cycle and carries
//   the key's new count, the max and min keys with their counts (lowest slot
//   on ties) and the empty, dropped and absent flags. The receiver cannot
//   stall; the beat is gone after that cycle.
//   Timing: the table rotates past a single compare/update head, once to
//   look the key up and once to apply the update and gather max/min. The
//   strobe is registered at the end of the apply pass; busy drops in the
//   strobe cycle, so a new request is taken only after the last one ends.
//   Reset: synchronous, active low; empties the table, clears busy and
//   out_valid. No clearing pass is needed.
module key_frequency_min_max_tracker_unit #(
  parameter int SLOTS      = kfmm_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = kfmm_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = kfmm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [KEY_BITS-1:0]   in_key,
  output logic                  out_valid,
  output logic [COUNT_BITS-1:0] out_key_count,
  output logic [KEY_BITS-1:0]   out_max_key,
  output logic [COUNT_BITS-1:0] out_max_count,
  output logic [KEY_BITS-1:0]   out_min_key,
  output logic [COUNT_BITS-1:0] out_min_count,
  output logic                  out_is_empty,
  output logic                  out_dropped,
  output logic                  out_was_absent
);
  import kfmm_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(SLOTS - 1);

  kfmm_state_t     state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             valid_r, valid_nxt;
  logic             last;
  logic             shift;
  kfmm_ctrl_t       ctrl;

  logic [KEY_BITS-1:0]   d_key   [SLOTS];
  logic [COUNT_BITS-1:0] d_count [SLOTS];
  logic                  d_used  [SLOTS];
  logic [KEY_BITS-1:0]   q_key   [SLOTS];
  logic [COUNT_BITS-1:0] q_count [SLOTS];
  logic                  q_used  [SLOTS];

  assign last = (pos_r == POS_LAST);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      ST_IDLE: begin
        pos_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pos_nxt = last ? '0 : pos_r + 1'b1;
        if (last) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        pos_nxt = last ? '0 : pos_r + 1'b1;
        if (last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pos_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    ctrl.load  = 1'b0;
    ctrl.scan  = 1'b0;
    ctrl.apply = 1'b0;
    valid_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
      end
      ST_APPLY: begin
        ctrl.apply = 1'b1;
        valid_nxt  = last;
      end
      default: begin
      end
    endcase
  end

  assign shift = ctrl.scan || ctrl.apply;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  generate
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i < SLOTS - 1) begin : g_link
        assign d_key[i]   = q_key[i+1];
        assign d_count[i] = q_count[i+1];
        assign d_used[i]  = q_used[i+1];
      end
      kfmm_cell #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .d_key   (d_key[i]),
        .d_count (d_count[i]),
        .d_used  (d_used[i]),
        .q_key   (q_key[i]),
        .q_count (q_count[i]),
        .q_used  (q_used[i])
      );
    end
  endgenerate

  kfmm_head #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_head (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .req_type   (in_req_type),
    .req_key    (in_key),
    .e_key      (q_key[0]),
    .e_count    (q_count[0]),
    .e_used     (q_used[0]),
    .w_key      (d_key[SLOTS-1]),
    .w_count    (d_count[SLOTS-1]),
    .w_used     (d_used[SLOTS-1]),
    .key_count  (out_key_count),
    .max_key    (out_max_key),
    .max_count  (out_max_count),
    .min_key    (out_min_key),
    .min_count  (out_min_count),
    .is_empty   (out_is_empty),
    .dropped    (out_dropped),
    .was_absent (out_was_absent)
  );

  assign out_valid = valid_r;

  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result beat");

  a_no_accept_mid_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_APPLY))
    else $error("result beat not preceded by the apply pass");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_max_count == '0 && out_min_count == '0))
    else $error("empty table reported non-zero counts");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> (out_min_count <= out_max_count && out_min_count != '0))
    else $error("min count above max count or zero");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_dropped && out_was_absent))
    else $error("dropped and absent both set");

endmodule

/* tb/key_frequency_min_max_tracker_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for key_frequency_min_max_tracker_unit: directed table and fill/drain
// random traffic, each result checked against a typed answer or a table model.
// Depends on kfmm_pkg and the unit's RTL.
module key_frequency_min_max_tracker_unit_tb;
  import kfmm_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  localparam int KEY_BITS   = KEY_BITS_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int LATENCY    = 2 * SLOTS;
  localparam int POOL_KEYS  = 24;
  localparam int SEGMENTS   = 25;
  localparam int SEG_BEATS  = 65;
  localparam int DIR_ROWS   = 25;
  localparam int MAX_PRINTS = 60;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_TOP = '1;

  typedef struct packed {
    count_t key_count;
    key_t   max_key;
    count_t max_count;
    key_t   min_key;
    count_t min_count;
    logic   is_empty;
    logic   dropped;
    logic   was_absent;
  } tally_answer_t;

  typedef struct packed {
    logic          op;
    key_t          key;
    logic          typed;
    tally_answer_t ans;
  } dir_row_t;

  // Typed rows carry their answer; fill rows rely on the table model.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_DEC, 32'h0000_0000, 1'b1, '{16'd0, 32'h0, 16'd0, 32'h0, 16'd0, 1'b1, 1'b0, 1'b1}},
    '{OP_INC, 32'h0000_0000, 1'b1, '{16'd1, 32'h0, 16'd1, 32'h0, 16'd1, 1'b0, 1'b0, 1'b0}},
    '{OP_INC, 32'hFFFF_FFFF, 1'b1, '{16'd1, 32'h0, 16'd1, 32'h0, 16'd1, 1'b0, 1'b0, 1'b0}},
    '{OP_INC, 32'hFFFF_FFFF, 1'b1,
      '{16'd2, 32'hFFFF_FFFF, 16'd2, 32'h0, 16'd1, 1'b0, 1'b0, 1'b0}},
    '{OP_DEC, 32'h0000_0000, 1'b1,
      '{16'd0, 32'hFFFF_FFFF, 16'd2, 32'hFFFF_FFFF, 16'd2, 1'b0, 1'b0, 1'b0}},
    '{OP_DEC, 32'hFFFF_FFFF, 1'b1,
      '{16'd1, 32'hFFFF_FFFF, 16'd1, 32'hFFFF_FFFF, 16'd1, 1'b0, 1'b0, 1'b0}},
    '{OP_DEC, 32'hFFFF_FFFF, 1'b1, '{16'd0, 32'h0, 16'd0, 32'h0, 16'd0, 1'b1, 1'b0, 1'b0}},
    '{OP_INC, 32'h0000_0001, 1'b0, '0},
    '{OP_INC, 32'h8000_0000, 1'b0, '0},
    '{OP_INC, 32'h5555_5555, 1'b0, '0},
    '{OP_INC, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_INC, 32'h1234_5678, 1'b0, '0},
    '{OP_INC, 32'h8765_4321, 1'b0, '0},
    '{OP_INC, 32'h0F0F_0F0F, 1'b0, '0},
    '{OP_INC, 32'hF0F0_F0F0, 1'b0, '0},
    '{OP_INC, 32'h0000_FFFF, 1'b0, '0},
    '{OP_INC, 32'hFFFF_0000, 1'b0, '0},
    '{OP_INC, 32'h7FFF_FFFF, 1'b0, '0},
    '{OP_INC, 32'hFFFF_FFFE, 1'b0, '0},
    '{OP_INC, 32'h0000_0100, 1'b0, '0},
    '{OP_INC, 32'h00FF_FF00, 1'b0, '0},
    '{OP_INC, 32'h3C3C_C3C3, 1'b0, '0},
    '{OP_INC, 32'hC001_D00D, 1'b0, '0},
    '{OP_INC, 32'hDEAD_BEEF, 1'b1, '{16'd0, 32'h1, 16'd1, 32'h1, 16'd1, 1'b0, 1'b1, 1'b0}},
    '{OP_DEC, 32'hCAFE_F00D, 1'b1, '{16'd0, 32'h1, 16'd1, 32'h1, 16'd1, 1'b0, 1'b0, 1'b1}}
  };

  logic   clk         = 1'b0;
  logic   rst_n       = 1'b0;
  logic   start       = 1'b0;
  logic   in_req_type = OP_INC;
  key_t   in_key      = '0;
  logic   busy;
  logic   out_valid;
  count_t out_key_count;
  key_t   out_max_key;
  count_t out_max_count;
  key_t   out_min_key;
  count_t out_min_count;
  logic   out_is_empty;
  logic   out_dropped;
  logic   out_was_absent;

  bit     held       [SLOTS];
  key_t   held_key   [SLOTS];
  count_t held_count [SLOTS];

  tally_answer_t pending_answers [$];
  int beats_sent;
  int results_seen;
  int drops_seen;
  int absents_seen;
  int empties_seen;
  int mismatches;

  key_frequency_min_max_tracker_unit #(
    .SLOTS(SLOTS),
    .KEY_BITS(KEY_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_key_count(out_key_count),
    .out_max_key(out_max_key),
    .out_max_count(out_max_count),
    .out_min_key(out_min_key),
    .out_min_count(out_min_count),
    .out_is_empty(out_is_empty),
    .out_dropped(out_dropped),
    .out_was_absent(out_was_absent)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tally_answer_t tally_request(logic op, key_t key);
    tally_answer_t a;
    int hit;
    int vacant;
    bit any;
    a = '0;
    hit = -1;
    vacant = -1;
    any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (held[i] && held_key[i] == key) hit = i;
      if (!held[i]) vacant = i;
    end
    if (op == OP_INC) begin
      if (hit >= 0) begin
        if (held_count[hit] != COUNT_TOP) held_count[hit] = held_count[hit] + 1'b1;
        a.key_count = held_count[hit];
      end else if (vacant < 0) begin
        a.dropped = 1'b1;
      end else begin
        held[vacant] = 1'b1;
        held_key[vacant] = key;
        held_count[vacant] = count_t'(1);
        a.key_count = count_t'(1);
      end
    end else if (hit < 0) begin
      a.was_absent = 1'b1;
    end else if (held_count[hit] <= 1) begin
      held[hit] = 1'b0;
      held_count[hit] = '0;
    end else begin
      held_count[hit] = held_count[hit] - 1'b1;
      a.key_count = held_count[hit];
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (held[i]) begin
        if (!any) begin
          any = 1'b1;
          a.max_key = held_key[i];
          a.min_key = held_key[i];
          a.max_count = held_count[i];
          a.min_count = held_count[i];
        end else begin
          if (held_count[i] > a.max_count) begin
            a.max_count = held_count[i];
            a.max_key = held_key[i];
          end
          if (held_count[i] < a.min_count) begin
            a.min_count = held_count[i];
            a.min_key = held_key[i];
          end
        end
      end
    end
    a.is_empty = !any;
    return a;
  endfunction

  task automatic report_mismatch(string what, key_t got, key_t want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at %0t, result %0d: %s got %h want %h",
               $time, results_seen, what, got, want);
  endtask

  // Hold start high across back-to-back beats; drop it only for a gap.
  task automatic issue(logic op, key_t key, int gap);
    tally_answer_t ans;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= op;
    in_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    ans = tally_request(op, key);
    pending_answers = {pending_answers, ans};
    beats_sent++;
  endtask

  always @(posedge clk) begin : watch_results
    tally_answer_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_answers.pop_front();
        if (out_key_count !== want.key_count)
          report_mismatch("key_count", key_t'(out_key_count), key_t'(want.key_count));
        if (out_max_key !== want.max_key) report_mismatch("max_key", out_max_key, want.max_key);
        if (out_max_count !== want.max_count)
          report_mismatch("max_count", key_t'(out_max_count), key_t'(want.max_count));
        if (out_min_key !== want.min_key) report_mismatch("min_key", out_min_key, want.min_key);
        if (out_min_count !== want.min_count)
          report_mismatch("min_count", key_t'(out_min_count), key_t'(want.min_count));
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", key_t'(out_is_empty), key_t'(want.is_empty));
        if (out_dropped !== want.dropped)
          report_mismatch("dropped", key_t'(out_dropped), key_t'(want.dropped));
        if (out_was_absent !== want.was_absent)
          report_mismatch("was_absent", key_t'(out_was_absent), key_t'(want.was_absent));
      end
      results_seen++;
      if (out_dropped === 1'b1) drops_seen++;
      if (out_was_absent === 1'b1) absents_seen++;
      if (out_is_empty === 1'b1) empties_seen++;
    end
  end

  initial begin : stimulus
    key_t   pool [POOL_KEYS];
    key_t   k;
    logic   op;
    bit     fill_bias;
    bit     no_idle;
    int     gap;
    int     n_held;
    int     pick;
    dir_row_t row;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      issue(row.op, row.key, $urandom_range(0, 8));
      if (row.typed) pending_answers[pending_answers.size() - 1] = row.ans;
    end

    // Alternate fill-heavy and drain-heavy stretches so the table swings full and empty.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      fill_bias = (seg % 2 == 0);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEG_BEATS; n++) begin
        if (fill_bias) op = ($urandom_range(0, 3) == 0) ? OP_DEC : OP_INC;
        else op = ($urandom_range(0, 3) == 0) ? OP_INC : OP_DEC;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          k = $urandom;
        end else begin
          k = pool[$urandom_range(0, POOL_KEYS - 1)];
          if (op == OP_DEC && pick <= 5) begin
            n_held = 0;
            foreach (held[i]) if (held[i]) n_held++;
            if (n_held > 0) begin
              pick = $urandom_range(1, n_held);
              foreach (held[i]) begin
                if (held[i]) begin
                  pick--;
                  if (pick == 0) k = held_key[i];
                end
              end
            end
          end
        end
        gap = no_idle ? 0 : $urandom_range(0, 8);
        issue(op, k, gap);
      end
      if (seg % 5 == 4) begin
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d beats, %0d results: %0d refused inserts, %0d absent decrements,",
             beats_sent, results_seen, drops_seen, absents_seen);
    $display("%0d empty-table answers, with the table swung between full and empty",
             empties_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(100_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
